[hw/rtl/nrmc_pkg.sv]
// nrmc_pkg: types, character codes and classification helpers for the
// rmc time/date parser. No dependencies; used by every rtl file.
`timescale 1ns / 1ps

package nrmc_pkg;

    // ascii codes the parser reacts to
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_G = 8'h47;
    localparam logic [7:0] CH_UPPER_M = 8'h4D;
    localparam logic [7:0] CH_UPPER_N = 8'h4E;
    localparam logic [7:0] CH_UPPER_P = 8'h50;
    localparam logic [7:0] CH_UPPER_R = 8'h52;
    localparam logic [7:0] CH_UPPER_S = 8'h53;
    localparam logic [7:0] CH_UPPER_V = 8'h56;
    localparam logic [7:0] CH_UPPER_W = 8'h57;
    localparam logic [7:0] HEX_TEN    = 8'd10;

    // field geometry
    localparam logic [3:0] FIELD_DIGITS   = 4'd6;
    localparam logic [3:0] COMMAS_TO_DATE = 4'd8;
    localparam logic [3:0] NAME_R_POS     = 4'd2;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // parse phases
    typedef enum logic [2:0] {
        PH_ERROR    = 3'd0,
        PH_NAME     = 3'd1,
        PH_TIME     = 3'd2,
        PH_BETWEEN  = 3'd3,
        PH_DATE     = 3'd4,
        PH_TAIL     = 3'd5,
        PH_CHECKSUM = 3'd6
    } phase_t;

    // classified item handed from front to back
    typedef struct packed {
        logic       is_tick;
        logic       allowed;
        logic       is_dollar;
        logic       is_star;
        logic       is_comma;
        logic       is_digit;
        logic       is_r;
        logic [7:0] hex_val;
        logic [7:0] ch;
    } item_t;

    // characters that may appear in a sentence
    function automatic logic char_allowed(input logic [7:0] c);
        logic ok;
        ok = (c inside {CH_DOLLAR, CH_STAR, CH_DOT, CH_COMMA, [CH_ZERO:CH_NINE],
                        [CH_UPPER_A:CH_UPPER_G], CH_UPPER_M, CH_UPPER_N,
                        CH_UPPER_P, CH_UPPER_R, CH_UPPER_S, CH_UPPER_V,
                        CH_UPPER_W});
        return ok;
    endfunction

    // checksum digit value, 8 bit wrapping as received
    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c > CH_NINE) begin
            v = c - CH_UPPER_A + HEX_TEN;
        end else begin
            v = c - CH_ZERO;
        end
        return v;
    endfunction

endpackage

[hw/rtl/nrmc_front.sv]
// nrmc_front: classifies each accepted character or tick into an item_t
// for the queue. Depends on nrmc_pkg.
`timescale 1ns / 1ps

module nrmc_front (
    input  logic               s_req_type,
    input  logic [7:0]         s_rx_byte,
    output nrmc_pkg::item_t    item
);
    import nrmc_pkg::*;

    // character classification
    always_comb begin
        item.is_tick   = s_req_type;
        item.allowed   = char_allowed(s_rx_byte);
        item.is_dollar = (s_rx_byte == CH_DOLLAR);
        item.is_star   = (s_rx_byte == CH_STAR);
        item.is_comma  = (s_rx_byte == CH_COMMA);
        item.is_digit  = (s_rx_byte inside {[CH_ZERO:CH_NINE]});
        item.is_r      = (s_rx_byte == CH_UPPER_R);
        item.hex_val   = hex_value(s_rx_byte);
        item.ch        = s_rx_byte;
    end

endmodule

[hw/rtl/nrmc_queue.sv]
// nrmc_queue: short first-in first-out queue of classified items between
// front and back. Depends on nrmc_pkg.
`timescale 1ns / 1ps

module nrmc_queue #(
    parameter int DEPTH = nrmc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  nrmc_pkg::item_t    push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output nrmc_pkg::item_t    pop_item
);
    import nrmc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t            slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    // handshake
    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[hw/rtl/nrmc_back.sv]
// nrmc_back: sentence state machine, captured digits, checksum and wait
// countdown; its state registers double as the result register.
// Depends on nrmc_pkg.
`timescale 1ns / 1ps

module nrmc_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         correction_delay,
    input  logic               item_valid,
    output logic               item_ready,
    input  nrmc_pkg::item_t    item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [23:0]        m_time_bcd,
    output logic [23:0]        m_date_bcd,
    output logic               m_time_valid,
    output logic [7:0]         m_wait_left
);
    import nrmc_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  pos_reg, pos_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  csum_reg, csum_next;
    logic [23:0] time_reg, time_next;
    logic [23:0] date_reg, date_next;
    logic        flag_reg, flag_next;
    logic [7:0]  wait_reg, wait_next;
    logic        out_valid_reg, out_valid_next;
    logic        take;
    logic        last_digit;
    logic [23:0] time_put, date_put;

    // item taken whenever the result slot is free or being emptied
    assign item_ready = !out_valid_reg || m_ready;
    assign take       = item_valid && item_ready;
    assign last_digit = (pos_reg == FIELD_DIGITS - 4'd1);

    // digit lanes with the current position replaced
    always_comb begin
        time_put = time_reg;
        date_put = date_reg;
        for (int i = 0; i < 6; i++) begin
            if (pos_reg == 4'(i)) begin
                time_put[(5 - i) * 4 +: 4] = item.ch[3:0];
                date_put[(5 - i) * 4 +: 4] = item.ch[3:0];
            end
        end
    end

    // next state
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        xor_next   = xor_reg;
        csum_next  = csum_reg;
        time_next  = time_reg;
        date_next  = date_reg;
        flag_next  = flag_reg;
        wait_next  = wait_reg;

        if (item.is_tick) begin
            if (flag_reg && (wait_reg != '0)) begin
                wait_next = wait_reg - 8'd1;
            end
        end else if (!item.allowed) begin
            phase_next = PH_ERROR;
        end else if (item.is_dollar) begin
            phase_next = PH_NAME;
            pos_next   = '0;
            xor_next   = '0;
        end else begin
            case (phase_reg)
                PH_NAME, PH_TIME, PH_DATE: begin
                    if (pos_reg >= FIELD_DIGITS) begin
                        phase_next = PH_ERROR;
                    end else begin
                        xor_next = xor_reg ^ item.ch;
                        if (phase_reg == PH_TIME) begin
                            flag_next = 1'b0;
                            time_next = time_put;
                        end
                        if (phase_reg == PH_DATE) begin
                            date_next = date_put;
                        end
                        if ((phase_reg == PH_NAME) && (pos_reg == NAME_R_POS)
                                && !item.is_r) begin
                            phase_next = PH_ERROR;
                        end else if ((phase_reg != PH_NAME) && !item.is_digit) begin
                            phase_next = PH_ERROR;
                        end else if (last_digit) begin
                            pos_next = '0;
                            case (phase_reg)
                                PH_NAME: phase_next = PH_TIME;
                                PH_TIME: phase_next = PH_BETWEEN;
                                default: phase_next = PH_TAIL;
                            endcase
                        end else begin
                            pos_next = pos_reg + 4'd1;
                        end
                    end
                end
                PH_BETWEEN: begin
                    xor_next = xor_reg ^ item.ch;
                    if (item.is_comma) begin
                        if (pos_reg == COMMAS_TO_DATE - 4'd1) begin
                            phase_next = PH_DATE;
                            pos_next   = '0;
                        end else begin
                            pos_next = pos_reg + 4'd1;
                        end
                    end
                end
                PH_TAIL: begin
                    if (item.is_star) begin
                        phase_next = PH_CHECKSUM;
                        pos_next   = '0;
                        csum_next  = '0;
                    end else begin
                        xor_next = xor_reg ^ item.ch;
                    end
                end
                PH_CHECKSUM: begin
                    if (pos_reg == '0) begin
                        csum_next = {item.hex_val[3:0], 4'h0};
                        pos_next  = 4'd1;
                    end else begin
                        csum_next = csum_reg | item.hex_val;
                        if (xor_reg == csum_next) begin
                            wait_next = correction_delay;
                            flag_next = 1'b1;
                        end
                        phase_next = PH_ERROR;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result slot
    always_comb begin
        out_valid_next = out_valid_reg;
        if (item_ready) begin
            out_valid_next = item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_ERROR;
            pos_reg       <= '0;
            xor_reg       <= '0;
            csum_reg      <= '0;
            time_reg      <= '0;
            date_reg      <= '0;
            flag_reg      <= 1'b0;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                xor_reg   <= xor_next;
                csum_reg  <= csum_next;
                time_reg  <= time_next;
                date_reg  <= date_next;
                flag_reg  <= flag_next;
                wait_reg  <= wait_next;
            end
        end
    end

    // result fields are the state after the last item
    assign m_valid      = out_valid_reg;
    assign m_time_bcd   = time_reg;
    assign m_date_bcd   = date_reg;
    assign m_time_valid = flag_reg;
    assign m_wait_left  = wait_reg;

endmodule

[hw/rtl/nmea_rmc_time_date_parser.sv]
// channel   direction  ports
// s_        in         s_valid s_ready s_req_type s_rx_byte
// m_        out        m_valid m_ready m_time_bcd m_date_bcd m_time_valid m_wait_left
// cfg_      in         cfg_valid cfg_ready cfg_data (correction_delay)
//
// one item per cycle sustained while m_ready is held high; each item is stored in
// a queue slot, then its result is registered in the back stage state registers.
// the back stage holds the result in its own state registers, so it advances
// only when the result slot is empty or being taken; the queue absorbs stalls.
// reset (synchronous, aresetn low) clears phase, digits, flag, count and queue.
// depends on nrmc_pkg, nrmc_front, nrmc_queue, nrmc_back.
`timescale 1ns / 1ps

module nmea_rmc_time_date_parser #(
    parameter int QUEUE_DEPTH = nrmc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [23:0] m_time_bcd,
    output logic [23:0] m_date_bcd,
    output logic        m_time_valid,
    output logic [7:0]  m_wait_left,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import nrmc_pkg::*;

    logic [7:0] delay_reg;
    item_t      front_item;
    item_t      head_item;
    logic       head_valid;
    logic       head_ready;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= '0;
        end else if (cfg_valid) begin
            delay_reg <= cfg_data;
        end
    end

    // classify incoming transfers
    nrmc_front u_front (
        .s_req_type (s_req_type),
        .s_rx_byte  (s_rx_byte),
        .item       (front_item)
    );

    // decoupling queue
    nrmc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_item  (front_item),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_item   (head_item)
    );

    // parser state and result
    nrmc_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .correction_delay (delay_reg),
        .item_valid       (head_valid),
        .item_ready       (head_ready),
        .item             (head_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_time_bcd       (m_time_bcd),
        .m_date_bcd       (m_date_bcd),
        .m_time_valid     (m_time_valid),
        .m_wait_left      (m_wait_left)
    );

endmodule
